// ===== rtl/confusion_and_event_scorer_defines.svh =====
// Assertion macros for the confusion and event scorer.
// Used by the top level only; defining SYNTH leaves the macros empty.
`ifndef CONFUSION_AND_EVENT_SCORER_DEFINES_SVH
`define CONFUSION_AND_EVENT_SCORER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication on clk, off while rst_n is low
`define CES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication on clk, off while rst_n is low
`define CES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CES_ASSERT_IMP(lbl, ante, cons, msg)
`define CES_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ces_pkg.sv =====
// Shared constants, command codes and control/status structs of the scorer.
// No dependencies; used by ces_ctrl, ces_datapath, the top level and the testbench.
package ces_pkg;

    localparam int NUM_CLASSES = 16;
    localparam int COUNT_BITS  = 32;

    localparam int CLASS_W    = 4;
    localparam int IDX_W      = $clog2(NUM_CLASSES);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int CELL_DEPTH = 1 << ADDR_W;
    localparam int SUM_W      = COUNT_BITS + ADDR_W;
    localparam int CHG_W      = 16;
    localparam int NUM_EVENTS = 9;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int RESULT_W    = 187;
    localparam int OUT_TDATA_W = 192;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_EVENT  = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // transfer taken on the input side
        logic walk_rd;    // read next matrix cell of the query walk
        logic q_sub;      // form FP, FN and total minus row
        logic complete;   // item finishes: side effects and result
        logic load_hold;  // move the held result to the output register
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic in_query;   // offered input item is a class query
        logic walk_last;  // walk is reading the last cell
        logic out_free;   // output register can take a result this cycle
    } stat_t;

endpackage

// ===== rtl/ces_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ces_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ces_ctrl.sv =====
// Sequencer of the scorer: one item at a time, query walk, result hand-off.
// Depends on ces_pkg.
module ces_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ces_pkg::stat_t  stat,
    output ces_pkg::ctrl_t  ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QWALK,
        ST_QDRAIN,
        ST_QSUB,
        ST_QTN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctrl       = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
                if (in_valid)
                begin
                    state_next = stat.in_query ? ST_QWALK : ST_EXEC;
                end
            end
            ST_EXEC, ST_QTN:
            begin
                ctrl.complete = 1'b1;
                state_next    = stat.out_free ? ST_IDLE : ST_HOLD;
            end
            ST_QWALK:
            begin
                ctrl.walk_rd = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_QDRAIN;
                end
            end
            ST_QDRAIN:
            begin
                state_next = ST_QSUB;
            end
            ST_QSUB:
            begin
                ctrl.q_sub = 1'b1;
                state_next = ST_QTN;
            end
            ST_HOLD:
            begin
                if (stat.out_free)
                begin
                    ctrl.load_hold = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ces_datapath.sv =====
// Datapath of the scorer: confusion RAM, segment tracker, event counters,
// query accumulators and output register. Depends on ces_pkg and ces_ram.
module ces_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ces_pkg::CLASS_W-1:0]          cfg_wdata,
    input  logic [ces_pkg::IN_TDATA_W-1:0]       in_data,
    input  logic [ces_pkg::IN_TUSER_W-1:0]       in_user,
    input  ces_pkg::ctrl_t                       ctrl,
    output ces_pkg::stat_t                       stat,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ces_pkg::OUT_TDATA_W-1:0]      out_data
);

    localparam int CB = ces_pkg::COUNT_BITS;
    localparam int AW = ces_pkg::ADDR_W;
    localparam int IW = ces_pkg::IDX_W;
    localparam int SW = ces_pkg::SUM_W;
    localparam int BUMP_W = ((CB > ces_pkg::CHG_W) ? CB : ces_pkg::CHG_W) + 1;

    // event counter slots
    localparam int CNT_DELETIONS    = 0;
    localparam int CNT_EV_FRAG      = 1;
    localparam int CNT_EV_FRAGMERGE = 2;
    localparam int CNT_EV_MERGE     = 3;
    localparam int CNT_CORRECT      = 4;
    localparam int CNT_RE_MERGE     = 5;
    localparam int CNT_RE_FRAGMERGE = 6;
    localparam int CNT_RE_FRAG      = 7;
    localparam int CNT_INSERTIONS   = 8;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_DELETION,
        EV_INSERTION,
        EV_CORRECT,
        EV_SPLIT,
        EV_JOINED,
        EV_SPLIT_JOINED,
        EV_UNCLASSIFIED
    } event_code_t;

    typedef struct packed {
        logic [31:0] event_value;
        logic [39:0] true_neg;
        logic [39:0] false_neg;
        logic [39:0] false_pos;
        logic [31:0] true_pos;
        event_code_t closed_event;
    } result_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [39:0] sat40(input logic [63:0] v);
        return (v > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : v[39:0];
    endfunction

    // input item
    ces_pkg::cmd_t                cmd_reg;
    logic [ces_pkg::CLASS_W-1:0]  t_reg;
    logic [ces_pkg::CLASS_W-1:0]  p_reg;
    logic [ces_pkg::CLASS_W-1:0]  q_reg;
    logic [3:0]                   sel_reg;
    logic [ces_pkg::CLASS_W-1:0]  null_reg;

    // segment state
    logic [ces_pkg::CLASS_W-1:0]  prev_t_reg;
    logic [ces_pkg::CLASS_W-1:0]  prev_p_reg;
    logic [ces_pkg::CHG_W-1:0]    tchg_reg;
    logic [ces_pkg::CHG_W-1:0]    pchg_reg;
    logic [CB-1:0]                evc_reg [ces_pkg::NUM_EVENTS];

    // matrix RAM and valid bits
    logic [ces_pkg::CELL_DEPTH-1:0] cell_vld_reg;
    logic                           rd_vld_reg;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [CB-1:0]                  ram_wdata;
    logic [CB-1:0]                  ram_rdata;
    logic [CB-1:0]                  cell_val;

    // query walk
    logic [AW-1:0]  walk_cnt_reg;
    logic           acc_en_reg;
    logic [AW-1:0]  acc_addr_reg;
    logic [SW-1:0]  tot_reg;
    logic [SW-1:0]  row_reg;
    logic [SW-1:0]  col_reg;
    logic [CB-1:0]  diag_reg;
    logic [SW-1:0]  fp_reg;
    logic [SW-1:0]  fn_reg;
    logic [SW-1:0]  rest_reg;

    // result path
    result_t        res_next;
    result_t        res_reg;
    result_t        out_reg;
    logic           out_valid_reg;
    logic           out_free;
    logic           out_load;

    // segment logic
    logic                         is_sample;
    logic                         is_flush;
    logic                         sample_ok;
    logic                         q_ok;
    logic                         do_sample;
    logic                         seg_close;
    logic [ces_pkg::CHG_W-1:0]    g_half;
    logic [ces_pkg::CHG_W-1:0]    p_half;
    event_code_t                  ev_code;
    logic [ces_pkg::CHG_W-1:0]    inc_amt [ces_pkg::NUM_EVENTS];
    logic [BUMP_W-1:0]            bump_sum [ces_pkg::NUM_EVENTS];
    logic [ces_pkg::CLASS_W-1:0]  base_t;
    logic [ces_pkg::CLASS_W-1:0]  base_p;
    logic [ces_pkg::CHG_W-1:0]    base_tc;
    logic [ces_pkg::CHG_W-1:0]    base_pc;
    logic [ces_pkg::CHG_W-1:0]    tchg_next;
    logic [ces_pkg::CHG_W-1:0]    pchg_next;
    logic [IW-1:0]                acc_row_idx;
    logic [IW-1:0]                acc_col_idx;
    logic [ces_pkg::CLASS_W-1:0]  in_t;
    logic [ces_pkg::CLASS_W-1:0]  in_p;

    assign in_t = in_data[3:0];
    assign in_p = in_data[7:4];

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (ctrl.complete && out_free) || ctrl.load_hold;

    assign stat.in_query  = (ces_pkg::cmd_t'(in_user) == ces_pkg::CMD_QUERY);
    assign stat.walk_last = (walk_cnt_reg == '1);
    assign stat.out_free  = out_free;

    // ---------------------------------------------------------------- RAM
    assign ram_re    = ctrl.accept || ctrl.walk_rd;
    assign ram_raddr = ctrl.accept ? {IW'(in_p), IW'(in_t)} : walk_cnt_reg;
    assign cell_val  = rd_vld_reg ? ram_rdata : '0;
    assign ram_we    = do_sample;
    assign ram_waddr = {IW'(p_reg), IW'(t_reg)};
    assign ram_wdata = (&cell_val) ? cell_val : cell_val + 1'b1;

    ces_ram #(
        .WIDTH (CB),
        .DEPTH (ces_pkg::CELL_DEPTH)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------ segments
    always_comb
    begin
        is_sample = (cmd_reg == ces_pkg::CMD_SAMPLE);
        is_flush  = (cmd_reg == ces_pkg::CMD_FLUSH);
        sample_ok = (int'(t_reg) < ces_pkg::NUM_CLASSES)
                 && (int'(p_reg) < ces_pkg::NUM_CLASSES);
        q_ok      = (int'(q_reg) < ces_pkg::NUM_CLASSES);
        do_sample = ctrl.complete && is_sample && sample_ok;
        seg_close = (ctrl.complete && is_flush)
                 || (do_sample && ((prev_t_reg != t_reg && prev_p_reg != p_reg)
                                || (t_reg == null_reg && p_reg == null_reg)));

        // halve, rounding up
        g_half = tchg_reg - (tchg_reg >> 1);
        p_half = pchg_reg - (pchg_reg >> 1);

        ev_code = EV_NONE;
        for (int k = 0; k < ces_pkg::NUM_EVENTS; k++)
        begin
            inc_amt[k] = '0;
        end
        if (seg_close && !(tchg_reg == '0 && pchg_reg == '0))
        begin
            priority if (p_half == '0 && g_half == 1)
            begin
                ev_code                = EV_DELETION;
                inc_amt[CNT_DELETIONS] = ces_pkg::CHG_W'(1);
            end
            else if (g_half == '0 && p_half == 1)
            begin
                ev_code                 = EV_INSERTION;
                inc_amt[CNT_INSERTIONS] = ces_pkg::CHG_W'(1);
            end
            else if (g_half == 1 && p_half < 2)
            begin
                ev_code              = EV_CORRECT;
                inc_amt[CNT_CORRECT] = ces_pkg::CHG_W'(1);
            end
            else if (g_half == 1 && p_half > 1)
            begin
                ev_code              = EV_SPLIT;
                inc_amt[CNT_EV_FRAG] = g_half;
                inc_amt[CNT_RE_FRAG] = p_half;
            end
            else if (g_half > 1 && p_half == 1)
            begin
                ev_code               = EV_JOINED;
                inc_amt[CNT_EV_MERGE] = g_half;
                inc_amt[CNT_RE_MERGE] = p_half;
            end
            else if (g_half > 1 && p_half > 1)
            begin
                ev_code                   = EV_SPLIT_JOINED;
                inc_amt[CNT_EV_FRAGMERGE] = g_half;
                inc_amt[CNT_RE_FRAGMERGE] = p_half;
            end
            else
            begin
                ev_code = EV_UNCLASSIFIED;
            end
        end

        for (int k = 0; k < ces_pkg::NUM_EVENTS; k++)
        begin
            bump_sum[k] = BUMP_W'(evc_reg[k]) + BUMP_W'(inc_amt[k]);
        end

        // a close resets tracking before the sample is counted
        base_t  = seg_close ? null_reg : prev_t_reg;
        base_p  = seg_close ? null_reg : prev_p_reg;
        base_tc = seg_close ? '0 : tchg_reg;
        base_pc = seg_close ? '0 : pchg_reg;
        tchg_next = base_tc + ces_pkg::CHG_W'(t_reg != base_t && base_tc != '1);
        pchg_next = base_pc + ces_pkg::CHG_W'(p_reg != base_p && base_pc != '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_reg   <= '0;
            prev_t_reg <= '0;
            prev_p_reg <= '0;
            tchg_reg   <= '0;
            pchg_reg   <= '0;
            for (int k = 0; k < ces_pkg::NUM_EVENTS; k++)
            begin
                evc_reg[k] <= '0;
            end
            cell_vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                null_reg <= cfg_wdata;
            end
            if (do_sample)
            begin
                prev_t_reg <= t_reg;
                prev_p_reg <= p_reg;
                tchg_reg   <= tchg_next;
                pchg_reg   <= pchg_next;
                cell_vld_reg[ram_waddr] <= 1'b1;
            end
            else if (seg_close)
            begin
                prev_t_reg <= null_reg;
                prev_p_reg <= null_reg;
                tchg_reg   <= '0;
                pchg_reg   <= '0;
            end
            for (int k = 0; k < ces_pkg::NUM_EVENTS; k++)
            begin
                if (inc_amt[k] != '0)
                begin
                    evc_reg[k] <= (bump_sum[k] > BUMP_W'({CB{1'b1}}))
                                  ? {CB{1'b1}} : bump_sum[k][CB-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------- item and walk
    assign acc_row_idx = acc_addr_reg[AW-1 -: IW];
    assign acc_col_idx = acc_addr_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= ctrl.walk_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rd_vld_reg <= cell_vld_reg[ram_raddr];
        end
        acc_addr_reg <= walk_cnt_reg;
        if (ctrl.accept)
        begin
            cmd_reg      <= ces_pkg::cmd_t'(in_user);
            t_reg        <= in_data[3:0];
            p_reg        <= in_data[7:4];
            q_reg        <= in_data[11:8];
            sel_reg      <= in_data[15:12];
            walk_cnt_reg <= '0;
            tot_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            diag_reg     <= '0;
        end
        else
        begin
            if (ctrl.walk_rd)
            begin
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
            end
            if (acc_en_reg)
            begin
                tot_reg <= tot_reg + SW'(cell_val);
                if (acc_row_idx == IW'(q_reg))
                begin
                    row_reg <= row_reg + SW'(cell_val);
                end
                if (acc_col_idx == IW'(q_reg))
                begin
                    col_reg <= col_reg + SW'(cell_val);
                end
                if (acc_row_idx == IW'(q_reg) && acc_col_idx == IW'(q_reg))
                begin
                    diag_reg <= cell_val;
                end
            end
        end
        if (ctrl.q_sub)
        begin
            fp_reg   <= row_reg - SW'(diag_reg);
            fn_reg   <= col_reg - SW'(diag_reg);
            rest_reg <= tot_reg - row_reg;
        end
    end

    // -------------------------------------------------------------- result
    always_comb
    begin
        res_next              = '0;
        res_next.closed_event = ev_code;
        if (cmd_reg == ces_pkg::CMD_QUERY && q_ok)
        begin
            res_next.true_pos  = sat32(64'(diag_reg));
            res_next.false_pos = sat40(64'(fp_reg));
            res_next.false_neg = sat40(64'(fn_reg));
            res_next.true_neg  = sat40(64'(rest_reg - fn_reg));
        end
        if (cmd_reg == ces_pkg::CMD_EVENT && int'(sel_reg) < ces_pkg::NUM_EVENTS)
        begin
            res_next.event_value = sat32(64'(evc_reg[sel_reg]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.complete && !out_free)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_reg <= ctrl.load_hold ? res_reg : res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {(ces_pkg::OUT_TDATA_W - ces_pkg::RESULT_W)'(0), out_reg};

endmodule

// ===== rtl/confusion_and_event_scorer.sv =====
// Top level of the confusion matrix and event analysis scorer.
// Depends on ces_pkg, ces_ctrl, ces_datapath and the assertion header.
//
//  channel   dir  handshake              payload (lowest bits first)
//  s_axis    in   tvalid/tready          tdata: true_class, predicted_class,
//                                        query_class, event_select; tuser: cmd
//  m_axis    out  tvalid/tready          tdata: closed_event, true_pos, false_pos,
//                                        false_neg, true_neg, event_value
//  cfg       in   cfg_we                 cfg_wdata: null_class
//
// Sample, event read and flush are accepted and then completed; a class query walks
// every matrix cell through the single RAM read port, then drains, subtracts and completes.
// Reset clears counters and the segment tracker at once; matrix cells are
// marked empty by per-cell valid bits, so no clearing pass follows reset.
// A result waiting on m_axis does not stop the next item being taken; a
// second finished result is held until the output register drains.
`include "confusion_and_event_scorer_defines.svh"

module confusion_and_event_scorer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ces_pkg::CLASS_W-1:0]       cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] true_class, [7:4] predicted_class, [11:8] query_class,
    // [15:12] event_select
    input  logic [ces_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [ces_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] closed_event, [34:3] true_pos, [74:35] false_pos,
    // [114:75] false_neg, [154:115] true_neg, [186:155] event_value, rest zero
    output logic [ces_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    ces_pkg::ctrl_t ctrl;
    ces_pkg::stat_t stat;

    ces_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ces_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // one item in flight: a transfer in always drops ready for the next cycle
    `CES_ASSERT_NXT(a_single_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")

    // controller issues at most one datapath command per cycle
    `CES_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0({ctrl.accept, ctrl.walk_rd, ctrl.q_sub, ctrl.complete, ctrl.load_hold}), "overlapping datapath commands")

    // a result finishing against a stalled output is held, input stays closed
    `CES_ASSERT_NXT(a_hold_blocks, ctrl.complete && !stat.out_free, m_axis_tvalid && !s_axis_tready, "held result lost or input reopened")

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for confusion_and_event_scorer: directed table, then phases of random
// segment traffic under several NULL-class settings, checked against a behavioural scorer.
// Depends on ces_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int TAIL_CYCLES = 20;
    localparam logic [31:0] CELL_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] FLIP_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        EV_NONE, EV_DELETION, EV_INSERTION, EV_CORRECT,
        EV_FRAG, EV_MERGE, EV_FRAGMERGE, EV_UNCLASSIFIED
    } seg_event_t;

    typedef enum logic [3:0] {
        SEL_DELETIONS, SEL_EV_FRAG, SEL_EV_FRAGMERGE, SEL_EV_MERGE, SEL_CORRECT,
        SEL_RE_MERGE, SEL_RE_FRAGMERGE, SEL_RE_FRAG, SEL_INSERTIONS,
        SEL_UNUSED = 4'd15
    } tally_sel_t;

    // same layout as m_axis_tdata[186:0]
    typedef struct packed {
        logic [31:0] event_value;
        logic [39:0] true_neg;
        logic [39:0] false_neg;
        logic [39:0] false_pos;
        logic [31:0] true_pos;
        logic [2:0]  closed_event;
    } score_t;

    typedef struct {
        ces_pkg::cmd_t cmd;
        logic [3:0]    truth;
        logic [3:0]    guess;
        logic [3:0]    query;
        logic [3:0]    sel;
        bit            fixed;
        seg_event_t    want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ces_pkg::CLASS_W-1:0]     cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // true_class, predicted_class, query_class, event_select
    logic [ces_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [ces_pkg::IN_TUSER_W-1:0]  s_axis_tuser;   // cmd
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // closed_event, TP, FP, FN, TN, event_value
    logic [ces_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    confusion_and_event_scorer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scorer state: cells indexed [predicted][true]
    logic [31:0] conf_cells [ces_pkg::NUM_CLASSES][ces_pkg::NUM_CLASSES];
    logic [31:0] event_tally [ces_pkg::NUM_EVENTS];
    logic [3:0]  background_class;
    logic [3:0]  last_truth, last_guess;
    logic [15:0] truth_flips, guess_flips;

    score_t      expected_scores[$];
    stim_row_t   directed_rows[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          stalled_cycles = 0;
    int          burst_left = 0;

    function automatic void clear_scorer();
        foreach (conf_cells[i, j])
            conf_cells[i][j] = '0;
        foreach (event_tally[i])
            event_tally[i] = '0;
        background_class = '0;
        last_truth = '0;
        last_guess = '0;
        truth_flips = '0;
        guess_flips = '0;
    endfunction

    function automatic void tally_add(tally_sel_t idx, logic [16:0] amount);
        logic [32:0] sum;
        sum = {1'b0, event_tally[idx]} + amount;
        event_tally[idx] = sum[32] ? CELL_MAX : sum[31:0];
    endfunction

    function automatic logic [2:0] close_segment();
        logic [16:0] g, pr;
        g = truth_flips;
        pr = guess_flips;
        truth_flips = '0;
        guess_flips = '0;
        last_truth = background_class;
        last_guess = background_class;
        if (g == 0 && pr == 0)
            return EV_NONE;
        // halve, rounding up
        g = g - g / 2;
        pr = pr - pr / 2;
        if (pr == 0 && g == 1)
        begin
            tally_add(SEL_DELETIONS, 1);
            return EV_DELETION;
        end
        if (g == 0 && pr == 1)
        begin
            tally_add(SEL_INSERTIONS, 1);
            return EV_INSERTION;
        end
        if (g == 1 && pr < 2)
        begin
            tally_add(SEL_CORRECT, 1);
            return EV_CORRECT;
        end
        if (g == 1 && pr > 1)
        begin
            tally_add(SEL_EV_FRAG, g);
            tally_add(SEL_RE_FRAG, pr);
            return EV_FRAG;
        end
        if (g > 1 && pr == 1)
        begin
            tally_add(SEL_EV_MERGE, g);
            tally_add(SEL_RE_MERGE, pr);
            return EV_MERGE;
        end
        if (g > 1 && pr > 1)
        begin
            tally_add(SEL_EV_FRAGMERGE, g);
            tally_add(SEL_RE_FRAGMERGE, pr);
            return EV_FRAGMERGE;
        end
        return EV_UNCLASSIFIED;
    endfunction

    function automatic logic [39:0] clip40(logic [63:0] v);
        return (v > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : v[39:0];
    endfunction

    function automatic score_t score_item(ces_pkg::cmd_t cmd, logic [3:0] t, logic [3:0] p,
                                          logic [3:0] q, logic [3:0] sel);
        score_t      r;
        logic [63:0] row_sum, col_sum, grand, diag;
        r = '0;
        case (cmd)
            ces_pkg::CMD_SAMPLE:
            begin
                if (t < ces_pkg::NUM_CLASSES && p < ces_pkg::NUM_CLASSES)
                begin
                    if (conf_cells[p][t] != CELL_MAX)
                        conf_cells[p][t] = conf_cells[p][t] + 1;
                    if ((last_truth != t && last_guess != p) ||
                        (t == background_class && p == background_class))
                        r.closed_event = close_segment();
                    if (t != last_truth && truth_flips != FLIP_MAX)
                        truth_flips = truth_flips + 1;
                    if (p != last_guess && guess_flips != FLIP_MAX)
                        guess_flips = guess_flips + 1;
                    last_truth = t;
                    last_guess = p;
                end
            end
            ces_pkg::CMD_QUERY:
            begin
                if (q < ces_pkg::NUM_CLASSES)
                begin
                    row_sum = '0;
                    col_sum = '0;
                    grand = '0;
                    foreach (conf_cells[i, j])
                    begin
                        grand += conf_cells[i][j];
                        if (i == q)
                            row_sum += conf_cells[i][j];
                        if (j == q)
                            col_sum += conf_cells[i][j];
                    end
                    diag = conf_cells[q][q];
                    r.true_pos = diag[31:0];
                    r.false_pos = clip40(row_sum - diag);
                    r.false_neg = clip40(col_sum - diag);
                    r.true_neg = clip40((grand - row_sum) - (col_sum - diag));
                end
            end
            ces_pkg::CMD_EVENT:
            begin
                if (sel < ces_pkg::NUM_EVENTS)
                    r.event_value = event_tally[sel];
            end
            default:
                r.closed_event = close_segment();
        endcase
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic void add_row(ces_pkg::cmd_t cmd, logic [3:0] t, logic [3:0] p,
                                    logic [3:0] q, logic [3:0] sel, bit fixed,
                                    seg_event_t want);
        stim_row_t row;
        row.cmd = cmd;
        row.truth = t;
        row.guess = p;
        row.query = q;
        row.sel = sel;
        row.fixed = fixed;
        row.want = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // one input transfer, then the sender's idle gap
    task automatic offer(ces_pkg::cmd_t cmd, logic [3:0] t, logic [3:0] p, logic [3:0] q,
                         logic [3:0] sel, bit fixed, seg_event_t want);
        score_t predicted;
        int     gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {sel, q, p, t};
        s_axis_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = score_item(cmd, t, p, q, sel);
        if (fixed)
        begin
            predicted = '0;
            predicted.closed_event = want;
        end
        expected_scores.insert(expected_scores.size(), predicted);

        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = idle_gap();
            if ($urandom_range(0, 29) == 0)
                burst_left = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_background(logic [3:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        background_class = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        score_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got = m_axis_tdata[ces_pkg::RESULT_W-1:0];
            if (expected_scores.size() == 0)
            begin
                $error("result transfer with nothing pending");
                mismatches++;
            end
            else
            begin
                want = expected_scores.pop_front();
                check_field("closed_event", want.closed_event, got.closed_event);
                check_field("true_pos", want.true_pos, got.true_pos);
                check_field("false_pos", want.false_pos, got.false_pos);
                check_field("false_neg", want.false_neg, got.false_neg);
                check_field("true_neg", want.true_neg, got.true_neg);
                check_field("event_value", want.event_value, got.event_value);
                check_field("tdata_pad", '0,
                            m_axis_tdata[ces_pkg::OUT_TDATA_W-1:ces_pkg::RESULT_W]);
            end
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: ready stretches and random gaps, one long hold-off to back the block up
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (500) @(negedge clk);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
            @(negedge clk);
            m_axis_tready <= 1'b1;
            repeat (n - 1) @(negedge clk);
            n = idle_gap();
            if (n > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [3:0]    cur_t, cur_p, ft, fp, fq, fs;
        ces_pkg::cmd_t cmd;
        int            r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        clear_scorer();

        // NULL is class 0 from reset
        add_row(ces_pkg::CMD_QUERY, 4'd3, 4'd9, 4'd0, SEL_CORRECT, 1, EV_NONE);
        add_row(ces_pkg::CMD_EVENT, 4'd0, 4'd0, 4'd0, SEL_UNUSED, 1, EV_NONE);
        add_row(ces_pkg::CMD_FLUSH, 4'd0, 4'd0, 4'd0, SEL_DELETIONS, 1, EV_NONE); // empty
        add_row(ces_pkg::CMD_SAMPLE, 4'd1, 4'd1, 4'd0, SEL_DELETIONS, 1, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd0, 4'd0, 4'd0, SEL_DELETIONS, 1, EV_CORRECT); // NULL
        add_row(ces_pkg::CMD_SAMPLE, 4'd2, 4'd0, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd0, 4'd3, 4'd0, SEL_DELETIONS, 0, EV_NONE); // deletion
        add_row(ces_pkg::CMD_SAMPLE, 4'd5, 4'd1, 4'd0, SEL_DELETIONS, 0, EV_NONE); // insertion
        add_row(ces_pkg::CMD_SAMPLE, 4'd5, 4'd2, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd5, 4'd3, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd6, 4'd6, 4'd0, SEL_DELETIONS, 0, EV_NONE); // fragmented
        add_row(ces_pkg::CMD_SAMPLE, 4'd7, 4'd6, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd8, 4'd6, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd9, 4'd9, 4'd0, SEL_DELETIONS, 0, EV_NONE); // merged
        add_row(ces_pkg::CMD_SAMPLE, 4'd10, 4'd9, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd10, 4'd10, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd11, 4'd10, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd11, 4'd11, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_FLUSH, 4'd15, 4'd15, 4'd15, SEL_UNUSED, 0, EV_NONE); // fragmerged
        add_row(ces_pkg::CMD_SAMPLE, 4'd0, 4'd1, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd0, 4'd2, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd0, 4'd3, 4'd0, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_SAMPLE, 4'd15, 4'd15, 4'd0, SEL_DELETIONS, 0, EV_NONE); // unclass.
        add_row(ces_pkg::CMD_QUERY, 4'd0, 4'd0, 4'd15, SEL_DELETIONS, 0, EV_NONE);
        add_row(ces_pkg::CMD_EVENT, 4'd0, 4'd0, 4'd0, SEL_INSERTIONS, 0, EV_NONE);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].cmd, directed_rows[i].truth, directed_rows[i].guess,
                  directed_rows[i].query, directed_rows[i].sel, directed_rows[i].fixed,
                  directed_rows[i].want);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       write_background(4'd15);
                1:       write_background(4'd0);
                default: write_background(4'($urandom_range(1, 14)));
            endcase
            cur_t = background_class;
            cur_p = background_class;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                ft = 4'($urandom);
                fp = 4'($urandom);
                fq = 4'($urandom);
                fs = 4'($urandom);
                r = $urandom_range(0, 99);
                if (r < 8)
                    cmd = ces_pkg::cmd_t'($urandom_range(0, 3));   // noise
                else if (r < 80)
                begin
                    // segment-shaped traffic: mostly one class moves at a time
                    cmd = ces_pkg::CMD_SAMPLE;
                    r = $urandom_range(0, 99);
                    if (r < 38)
                        cur_t = 4'($urandom);
                    else if (r < 76)
                        cur_p = 4'($urandom);
                    else if (r < 84)
                    begin
                        cur_t = 4'($urandom);
                        cur_p = 4'($urandom);
                    end
                    else if (r < 92)
                    begin
                        cur_t = background_class;
                        cur_p = background_class;
                    end
                    ft = cur_t;
                    fp = cur_p;
                end
                else if (r < 83)
                    cmd = ces_pkg::CMD_QUERY;
                else if (r < 93)
                begin
                    cmd = ces_pkg::CMD_EVENT;
                    fs = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                      : 4'($urandom_range(0, 8));
                end
                else
                    cmd = ces_pkg::CMD_FLUSH;
                offer(cmd, ft, fp, fq, fs, 0, EV_NONE);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_scores.size() != 0)
        begin
            $error("%0d results never arrived", expected_scores.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== confusion_and_event_scorer.f =====
+incdir+rtl
rtl/ces_pkg.sv
rtl/ces_ram.sv
rtl/ces_ctrl.sv
rtl/ces_datapath.sv
rtl/confusion_and_event_scorer.sv
sim/testbench.sv
